[src/assert_macros.svh]
// Assertion macros for the checker file.
// Clock is clock, reset is reset (synchronous, active high).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/plk_pkg.sv]
// Shared constants, codes and types of the parameter lock smoother.
// No dependencies.
package plk_pkg;

   localparam int NUM_PARAMS = 16;
   localparam int NUM_STEPS  = 16;

   localparam int VAL_W      = 16;
   localparam int SLOT_W     = 4;
   localparam int MODE_W     = 3;
   localparam int FACTOR_W   = 16;
   localparam int DEADBAND_W = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int CNT_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int SP_W  = $clog2(NUM_STEPS);

   localparam logic [FACTOR_W-1:0]   FACTOR_RESET   = FACTOR_W'(32768);
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(41);

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 3'd0,
      MODE_RECORD = 3'd1,
      MODE_START  = 3'd2,
      MODE_STOP   = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTH_FACTOR = 1'b0,
      CSR_DEADBAND      = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctl_state_type;

   // value pair a cell hands down the chain
   typedef struct packed {
      logic signed [VAL_W-1:0] cur;
      logic signed [VAL_W-1:0] prev;
   } link_type;

   // broadcast control to every cell
   typedef struct packed {
      logic            load;
      logic            shift;
      logic            copy;
      logic            clear;
      logic [SP_W-1:0] sp;
   } cell_ctrl_type;

   // smoothed value write-back
   typedef struct packed {
      logic                    we;
      logic [CNT_W-1:0]        slot;
      logic signed [VAL_W-1:0] value;
   } wb_type;

endpackage

[src/parameter_lock_smoother.sv]
// Parameter lock step sequencer with one-pole smoothing, top level.
// Record, start, stop and clear beats are taken back to back; a tick holds off the
// next beat until every parameter is issued and the multiply stage drains: one parameter
// per cycle through the shared multiply pair while the result stream does not stall.
// Synchronous reset clears the table, smoothed values, step and recording flag.
module parameter_lock_smoother import plk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // [3:0] param_index, [19:4] value, [23:20] zero
   input  logic [MODE_W-1:0]     req_tuser,  // [2:0] mode
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,  // [3:0] param_slot, [19:4] smoothed, [23:20] zero
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ---------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------
   ctl_state_type           state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SP_W-1:0]         sp_ff, sp_in;
   logic                    rec_ff, rec_in;
   logic [FACTOR_W-1:0]     factor_ff, factor_in;
   logic [DEADBAND_W-1:0]   deadband_ff, deadband_in;

   logic                    accept;
   logic                    is_tick, is_record, is_start, is_stop, is_clear;
   logic                    issue;
   logic                    last_issue;
   logic                    adv;
   logic                    busy;
   logic [SLOT_W-1:0]       req_param_index;
   logic signed [VAL_W-1:0] req_value;

   cell_ctrl_type           cell_ctrl;
   wb_type                  wb;
   link_type                link_out [NUM_PARAMS];
   link_type                link_in  [NUM_PARAMS];

   logic [CNT_W-1:0]        res_slot;
   logic signed [VAL_W-1:0] res_value;

   assign req_param_index = req_tdata[SLOT_W-1:0];
   assign req_value       = req_tdata[SLOT_W+VAL_W-1:SLOT_W];

   assign accept    = req_tvalid && req_tready;
   assign is_tick   = accept && (req_tuser == MODE_TICK);
   assign is_record = accept && (req_tuser == MODE_RECORD);
   assign is_start  = accept && (req_tuser == MODE_START);
   assign is_stop   = accept && (req_tuser == MODE_STOP);
   assign is_clear  = accept && (req_tuser == MODE_CLEAR);

   assign last_issue = (cnt_ff == CNT_W'(NUM_PARAMS - 1));

   // ---------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_tick) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (issue && last_issue) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   // ready waits for the multiply stage to drain so the last write-back
   // lands before the next beat can read the cells
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = !busy;
         ST_RUN:  issue      = adv;
         default: begin
            req_tready = 1'b0;
            issue      = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // counter, step pointer, recording flag, registers
   // ---------------------------------------------------------------
   always_comb begin
      cnt_in = cnt_ff;
      if (is_tick) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // step advances on the tick beat while recording; the links already hold this step
   always_comb begin
      sp_in = sp_ff;
      if (is_tick && rec_ff) begin
         sp_in = (sp_ff == SP_W'(NUM_STEPS - 1)) ? '0 : sp_ff + SP_W'(1);
      end
   end

   always_comb begin
      rec_in = rec_ff;
      if (is_start) begin
         rec_in = 1'b1;
      end else if (is_stop) begin
         rec_in = 1'b0;
      end
   end

   always_comb begin
      factor_in   = factor_ff;
      deadband_in = deadband_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SMOOTH_FACTOR: factor_in   = csr_wdata[FACTOR_W-1:0];
            CSR_DEADBAND:      deadband_in = csr_wdata[DEADBAND_W-1:0];
            default: begin
               factor_in   = factor_ff;
               deadband_in = deadband_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         sp_ff       <= '0;
         rec_ff      <= 1'b0;
         factor_ff   <= FACTOR_RESET;
         deadband_ff <= DEADBAND_RESET;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         sp_ff       <= sp_in;
         rec_ff      <= rec_in;
         factor_ff   <= factor_in;
         deadband_ff <= deadband_in;
      end
   end

   // ---------------------------------------------------------------
   // cell chain: tick loads every link, then the chain shifts toward
   // cell 0 once per issue, cell 0 feeding the smoother
   // ---------------------------------------------------------------
   assign cell_ctrl.load  = is_tick;
   assign cell_ctrl.shift = issue;
   assign cell_ctrl.copy  = is_start;
   assign cell_ctrl.clear = is_clear;
   assign cell_ctrl.sp    = sp_ff;

   for (genvar i = 0; i < NUM_PARAMS; i++) begin : g_cell
      logic rec_we;
      logic wb_we;

      // record only while recording; indexes past the row never match
      assign rec_we = is_record && rec_ff && (req_param_index == SLOT_W'(i));
      assign wb_we  = wb.we && (wb.slot == CNT_W'(i));

      if (i == NUM_PARAMS - 1) begin : g_tail
         assign link_in[i] = '0;
      end else begin : g_body
         assign link_in[i] = link_out[i+1];
      end

      plk_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .rec_we    (rec_we),
         .rec_value (req_value),
         .wb_we     (wb_we),
         .wb_value  (wb.value),
         .link_in   (link_in[i]),
         .link_out  (link_out[i])
      );
   end

   // ---------------------------------------------------------------
   // shared smoother with result register
   // ---------------------------------------------------------------
   plk_smooth u_smooth (
      .clock     (clock),
      .reset     (reset),
      .factor    (factor_ff),
      .deadband  (deadband_ff),
      .issue     (issue),
      .in_pair   (link_out[0]),
      .in_slot   (cnt_ff),
      .in_last   (last_issue),
      .out_ready (rsp_tready),
      .adv       (adv),
      .busy      (busy),
      .wb        (wb),
      .out_valid (rsp_tvalid),
      .out_slot  (res_slot),
      .out_value (res_value),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, res_value, SLOT_W'(res_slot)};

endmodule

[src/plk_cell.sv]
// One parameter cell: its row of step values, its smoothed value and a link stage.
// Depends on plk_pkg.
module plk_cell import plk_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctrl_type           ctrl,
   input  logic                    rec_we,
   input  logic signed [VAL_W-1:0] rec_value,
   input  logic                    wb_we,
   input  logic signed [VAL_W-1:0] wb_value,
   input  link_type                link_in,
   output link_type                link_out
);

   logic signed [VAL_W-1:0] steps_ff [NUM_STEPS];
   logic signed [VAL_W-1:0] steps_in [NUM_STEPS];
   logic signed [VAL_W-1:0] sm_ff, sm_in;
   link_type                link_ff, link_in_nxt;

   always_comb begin
      for (int s = 0; s < NUM_STEPS; s++) begin
         steps_in[s] = steps_ff[s];
      end
      sm_in = sm_ff;
      if (ctrl.clear) begin
         for (int s = 0; s < NUM_STEPS; s++) begin
            steps_in[s] = '0;
         end
         sm_in = '0;
      end else begin
         if (ctrl.copy) begin
            for (int s = 0; s < NUM_STEPS; s++) begin
               steps_in[s] = steps_ff[ctrl.sp];
            end
         end
         if (rec_we) begin
            steps_in[ctrl.sp] = rec_value;
         end
         if (wb_we) begin
            sm_in = wb_value;
         end
      end
   end

   always_comb begin
      link_in_nxt = link_ff;
      if (ctrl.load) begin
         link_in_nxt.cur  = steps_ff[ctrl.sp];
         link_in_nxt.prev = sm_ff;
      end else if (ctrl.shift) begin
         link_in_nxt = link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STEPS; s++) begin
            steps_ff[s] <= '0;
         end
         sm_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STEPS; s++) begin
            steps_ff[s] <= steps_in[s];
         end
         sm_ff <= sm_in;
      end
   end

   always_ff @(posedge clock) begin
      link_ff <= link_in_nxt;
   end

   assign link_out = link_ff;

endmodule

[src/plk_smooth.sv]
// Shared one-pole smoother: multiply pair, then round, saturate, deadband
// into the result register. Depends on plk_pkg.
module plk_smooth import plk_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [FACTOR_W-1:0]     factor,
   input  logic [DEADBAND_W-1:0]   deadband,
   input  logic                    issue,
   input  link_type                in_pair,
   input  logic [CNT_W-1:0]        in_slot,
   input  logic                    in_last,
   input  logic                    out_ready,
   output logic                    adv,
   output logic                    busy,
   output wb_type                  wb,
   output logic                    out_valid,
   output logic [CNT_W-1:0]        out_slot,
   output logic signed [VAL_W-1:0] out_value,
   output logic                    out_last
);

   localparam int PROD_W  = VAL_W + FACTOR_W + 2;
   localparam int ACC_W   = PROD_W + 1;
   localparam int Q_W     = ACC_W - FACTOR_W;
   localparam int MAG_W   = VAL_W + 1;
   localparam logic signed [Q_W-1:0] VMAX = Q_W'((1 <<< (VAL_W - 1)) - 1);
   localparam logic signed [Q_W-1:0] VMIN = -Q_W'(1 <<< (VAL_W - 1));

   logic                       a_valid_ff, a_valid_in;
   logic signed [PROD_W-1:0]   a_cur_ff, a_cur_in;
   logic signed [PROD_W-1:0]   a_prev_ff, a_prev_in;
   logic [CNT_W-1:0]           a_slot_ff, a_slot_in;
   logic                       a_last_ff, a_last_in;
   logic                       out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]           out_slot_ff, out_slot_in;
   logic signed [VAL_W-1:0]    out_value_ff, out_value_in;
   logic                       out_last_ff, out_last_in;

   logic [FACTOR_W:0]          wgt;
   logic signed [FACTOR_W+1:0] wgt_s;
   logic signed [FACTOR_W+1:0] fac_s;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [Q_W-1:0]      q;
   logic signed [VAL_W-1:0]    sat;
   logic signed [MAG_W-1:0]    ext;
   logic [MAG_W-1:0]           mag;
   logic signed [VAL_W-1:0]    res;

   assign adv  = !out_valid_ff || out_ready;
   assign busy = a_valid_ff;

   // weights: cur * (1 - f), prev * f
   always_comb begin
      wgt   = (FACTOR_W+1)'(1 <<< FACTOR_W) - {1'b0, factor};
      wgt_s = {1'b0, wgt};
      fac_s = {2'b00, factor};
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_cur_in   = a_cur_ff;
      a_prev_in  = a_prev_ff;
      a_slot_in  = a_slot_ff;
      a_last_in  = a_last_ff;
      if (adv) begin
         a_valid_in = issue;
         if (issue) begin
            a_cur_in  = in_pair.cur * wgt_s;
            a_prev_in = in_pair.prev * fac_s;
            a_slot_in = in_slot;
            a_last_in = in_last;
         end
      end
   end

   // round half up, saturate, deadband
   always_comb begin
      acc = ACC_W'(a_cur_ff) + ACC_W'(a_prev_ff);
      rnd = acc + ACC_W'(1 <<< (FACTOR_W - 1));
      q   = rnd[ACC_W-1:FACTOR_W];
      if (q > VMAX) begin
         sat = VAL_W'(VMAX);
      end else if (q < VMIN) begin
         sat = VAL_W'(VMIN);
      end else begin
         sat = q[VAL_W-1:0];
      end
      ext = {sat[VAL_W-1], sat};
      mag = ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
      res = (mag < {2'b00, deadband}) ? '0 : sat;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_slot_in  = out_slot_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (adv) begin
         out_valid_in = a_valid_ff;
         if (a_valid_ff) begin
            out_slot_in  = a_slot_ff;
            out_value_in = res;
            out_last_in  = a_last_ff;
         end
      end
   end

   assign wb.we    = adv && a_valid_ff;
   assign wb.slot  = a_slot_ff;
   assign wb.value = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_cur_ff     <= a_cur_in;
      a_prev_ff    <= a_prev_in;
      a_slot_ff    <= a_slot_in;
      a_last_ff    <= a_last_in;
      out_slot_ff  <= out_slot_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_slot  = out_slot_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

[src/plk_checker.sv]
// Port-level checker for parameter_lock_smoother, bound to the top level.
// Depends on plk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plk_checker import plk_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [23:0]           req_tdata,
   input logic [MODE_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [23:0]           rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // stalled result beat stays up and holds
   `CHK_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp beat dropped while stalled")
   `CHK_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp beat changed while stalled")

   // the marked beat carries the final parameter
   `CHK_IMPLY(a_last_slot, rsp_tvalid && rsp_tlast, rsp_tdata[SLOT_W-1:0] == SLOT_W'(NUM_PARAMS - 1), "last beat on wrong slot")

   // a tick occupies the block, no beat taken right after it
   `CHK_NEXT(a_tick_busy, req_tvalid && req_tready && (req_tuser == MODE_TICK), !req_tready, "request taken during tick run")

endmodule

bind parameter_lock_smoother plk_checker u_plk_checker (.*);

[sim/tb_parameter_lock_smoother.sv]
`timescale 1ns / 100ps
// Self-checking bench for parameter_lock_smoother: directed and random event streams.
// Depends on plk_pkg and the parameter_lock_smoother RTL; predicts every result beat itself.
module tb_parameter_lock_smoother;
   import plk_pkg::*;

   // mode codes the block must ignore
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   // a tick holds the input until every parameter is issued and the multiply stage drains; give it some margin
   localparam int TICK_SETTLE = NUM_PARAMS + 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SHOWN_MISMATCHES = 10;

   typedef logic signed [VAL_W-1:0] level_type;

   // one result beat as the block should send it
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      level_type         level;
      logic              last;
   } level_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;   // [3:0] param_index, [19:4] value, [23:20] zero
   logic [MODE_W-1:0]     req_tuser = '0;   // [2:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;        // [3:0] param_slot, [19:4] smoothed, [23:20] zero
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   parameter_lock_smoother dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Shadow copy of the sequencer state
   // ---------------------------------------------------------------
   level_type           lock_table [NUM_PARAMS][NUM_STEPS];
   level_type           held_level [NUM_PARAMS];
   int                  shadow_step = 0;
   logic                shadow_rec = 1'b0;
   logic [FACTOR_W-1:0] shadow_factor = FACTOR_RESET;
   int                  shadow_deadband = DEADBAND_RESET;

   level_beat_type level_queue [$];

   int mismatches = 0;
   int beats_sent = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int cycles = 0;
   int burst_left = 0;

   initial begin
      for (int p = 0; p < NUM_PARAMS; p++) begin
         held_level[p] = '0;
         for (int s = 0; s < NUM_STEPS; s++) lock_table[p][s] = '0;
      end
   end

   // One-pole step: mix target and held value by the factor (Q0.16), round half up,
   // clamp to Q4.12, then squash anything inside the deadband.
   function automatic level_type one_pole_gate(level_type target, level_type held);
      longint f, t, h, acc, r, mag;
      f   = shadow_factor;
      t   = target;
      h   = held;
      acc = t * (65536 - f) + h * f;
      r   = (acc + 32768) >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      mag = (r < 0) ? -r : r;
      if (mag < shadow_deadband) r = 0;
      return level_type'(r);
   endfunction

   // Apply one accepted beat to the shadow state, queue the beats a tick causes.
   task automatic shadow_event(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] idx, level_type val);
      level_beat_type b;
      level_type      c;
      case (mode)
         MODE_TICK: begin
            for (int p = 0; p < NUM_PARAMS; p++) begin
               held_level[p] = one_pole_gate(lock_table[p][shadow_step], held_level[p]);
               b.slot  = SLOT_W'(p);
               b.level = held_level[p];
               b.last  = (p == NUM_PARAMS - 1);
               level_queue.push_back(b);
            end
            if (shadow_rec) shadow_step = (shadow_step + 1) % NUM_STEPS;
         end
         MODE_RECORD: begin
            if (shadow_rec && idx < NUM_PARAMS) lock_table[idx][shadow_step] = val;
         end
         MODE_START: begin
            shadow_rec = 1'b1;
            for (int p = 0; p < NUM_PARAMS; p++) begin
               c = lock_table[p][shadow_step];
               for (int s = 0; s < NUM_STEPS; s++) lock_table[p][s] = c;
            end
         end
         MODE_STOP: shadow_rec = 1'b0;
         MODE_CLEAR: begin
            for (int p = 0; p < NUM_PARAMS; p++) begin
               held_level[p] = '0;
               for (int s = 0; s < NUM_STEPS; s++) lock_table[p][s] = '0;
            end
         end
         default: ;   // unused codes leave everything alone
      endcase
   endtask

   // ---------------------------------------------------------------
   // Request side: bursty sender, one beat per call
   // ---------------------------------------------------------------
   task automatic push_event(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] idx, level_type val);
      int gap;
      if (burst_left == 0) begin
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {4'b0000, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow_event(mode, idx, val);
      beats_sent++;
      if (mode == MODE_TICK) ticks_sent++;
   endtask

   // Park the sender and wait for every queued beat; with hold, also let the
   // block run out its tick so a register write lands on an idle block.
   task automatic wait_drained(bit hold);
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (level_queue.size() != 0) @(posedge clock);
      if (hold) repeat (TICK_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_SMOOTH_FACTOR) shadow_factor = data[FACTOR_W-1:0];
      else shadow_deadband = data[DEADBAND_W-1:0];
      csr_writes++;
   endtask

   task automatic set_regs(logic [FACTOR_W-1:0] factor, logic [DEADBAND_W-1:0] band);
      wait_drained(1'b1);
      write_csr(CSR_SMOOTH_FACTOR, CSR_DATA_W'(factor));
      write_csr(CSR_DEADBAND, CSR_DATA_W'(band));
   endtask

   function automatic level_type pick_value();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return level_type'($urandom_range(0, 400)) - 16'sd200;
         default: return level_type'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------
   int stall_style = 0;
   int stall_left = 0;
   int stall_phase = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_left  = $urandom_range(32, 128);
      end
      stall_left--;
      stall_phase++;
      case (stall_style)
         0:       rsp_tready <= 1'b1;                          // wide open
         1:       rsp_tready <= ($urandom_range(0, 9) < 7);    // random drops
         default: rsp_tready <= ((stall_phase % 7) < 4);       // regular stall slots
      endcase
   end

   task automatic note_mismatch(string what, level_beat_type want, level_beat_type got);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
         $display("[%0t] %s: expected slot %0d level %0d last %0b, got slot %0d level %0d last %0b",
                  $realtime, what, want.slot, want.level, want.last,
                  got.slot, got.level, got.last);
   endtask

   always @(posedge clock) begin
      level_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.slot  = rsp_tdata[3:0];
         got.level = rsp_tdata[19:4];
         got.last  = rsp_tlast;
         results_seen++;
         if (level_queue.size() == 0) begin
            note_mismatch("unexpected beat", '0, got);
         end else begin
            want = level_queue.pop_front();
            if (got !== want) note_mismatch("field mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still owed", cycles, level_queue.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Empty table, recording off: ignored records, unused codes, stop while idle.
   task automatic test_idle_table();
      push_event(MODE_TICK, '0, '0);
      push_event(MODE_RECORD, 4'hF, 16'shFFFF);   // not recording, dropped
      for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
         push_event(MODE_UNUSED_LO + MODE_W'(m - MODE_UNUSED_LO), 4'hA, 16'sh5A5A);
      push_event(MODE_STOP, '0, '0);
      push_event(MODE_TICK, '0, '0);
   endtask

   // Value extremes at both end slots, step advance, repeated start, hold, clear.
   task automatic test_record_extremes();
      push_event(MODE_START, '0, '0);
      push_event(MODE_RECORD, 4'h0, 16'sh7FFF);
      push_event(MODE_RECORD, 4'hF, 16'sh8000);
      push_event(MODE_RECORD, 4'hA, 16'sh5A5A);
      push_event(MODE_RECORD, 4'h5, 16'shA5A5);
      push_event(MODE_TICK, '0, '0);
      push_event(MODE_RECORD, 4'h0, 16'sh8000);
      push_event(MODE_TICK, '0, '0);
      push_event(MODE_START, '0, '0);             // start while recording: copy again
      push_event(MODE_TICK, '0, '0);
      push_event(MODE_STOP, '0, '0);
      push_event(MODE_TICK, '0, '0);               // step holds
      push_event(MODE_TICK, '0, '0);
      push_event(MODE_CLEAR, '0, '0);
      push_event(MODE_TICK, '0, '0);
   endtask

   // Corners of both registers with full-scale values in the table.
   task automatic test_register_extremes();
      logic [FACTOR_W-1:0]   factors [5] = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd1};
      logic [DEADBAND_W-1:0] bands   [5] = '{15'd0, 15'd32767, 15'd0, 15'd32767, 15'd1};
      for (int k = 0; k < 5; k++) begin
         set_regs(factors[k], bands[k]);
         push_event(MODE_START, '0, '0);
         push_event(MODE_RECORD, 4'h3, 16'sh7FFF);
         push_event(MODE_RECORD, 4'h7, 16'sh8000);
         push_event(MODE_RECORD, 4'hC, 16'sh0001);
         push_event(MODE_TICK, '0, '0);
         push_event(MODE_TICK, '0, '0);
      end
   endtask

   // Sessions: new register setting, usually a start, then a recording-heavy
   // mix of records and ticks with some starts, stops, clears and junk codes.
   task automatic test_random_sessions(int target);
      int counted, len, r;
      logic [FACTOR_W-1:0]   factor;
      logic [DEADBAND_W-1:0] band;
      logic [MODE_W-1:0]     mode;
      counted = 0;
      while (counted < target) begin
         case ($urandom_range(0, 4))
            0:       factor = '0;
            1:       factor = '1;
            2:       factor = FACTOR_RESET;
            default: factor = FACTOR_W'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0:       band = '0;
            1:       band = '1;
            2:       band = DEADBAND_W'($urandom_range(0, 64));
            default: band = DEADBAND_W'($urandom_range(0, 32767));
         endcase
         set_regs(factor, band);
         if ($urandom_range(0, 9) < 8) begin
            push_event(MODE_START, '0, '0);
            counted++;
         end
         len = $urandom_range(20, 40);
         for (int i = 0; i < len && counted < target; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) mode = MODE_RECORD;
            else if (r < 75) mode = MODE_TICK;
            else if (r < 82) mode = MODE_START;
            else if (r < 89) mode = MODE_STOP;
            else if (r < 93) mode = MODE_CLEAR;
            else mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            counted++;
            push_event(mode, SLOT_W'($urandom_range(0, NUM_PARAMS - 1)), pick_value());
            // sender backs off until the block has nothing left to say
            if ($urandom_range(0, 24) == 0) wait_drained(1'b0);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_table();
      test_record_extremes();
      test_register_extremes();
      test_random_sessions(120);

      wait_drained(1'b1);
      mismatches += level_queue.size();
      $display("sent %0d beats (%0d ticks), checked %0d result beats, %0d register writes",
               beats_sent, ticks_sent, results_seen, csr_writes);
      $display("covered factor/deadband corners, recording on and off, clears and junk codes");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
